// ----- sv/ilp_pkg.sv -----
`default_nettype none

package ilp_pkg;

    // Field widths of the item ports
    localparam int CMD_W    = 2;
    localparam int POS_W    = 8;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 4;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DUMP   = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OOB   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

    typedef logic [1:0] sel_t;

    // Link read address select
    localparam sel_t RA_FREE = 2'd0;
    localparam sel_t RA_LIST = 2'd1;
    localparam sel_t RA_LRD  = 2'd2;

    // Link write address select
    localparam sel_t WA_N    = 2'd0;
    localparam sel_t WA_PREV = 2'd1;
    localparam sel_t WA_CUR  = 2'd2;

    // Link write data select
    localparam sel_t WD_LIST = 2'd0;
    localparam sel_t WD_LRD  = 2'd1;
    localparam sel_t WD_N    = 2'd2;
    localparam sel_t WD_FREE = 2'd3;

    // Free head update
    localparam sel_t FH_HOLD     = 2'd0;
    localparam sel_t FH_POP      = 2'd1;
    localparam sel_t FH_PUSH_N   = 2'd2;
    localparam sel_t FH_PUSH_CUR = 2'd3;

    // List head update
    localparam sel_t LH_HOLD = 2'd0;
    localparam sel_t LH_N    = 2'd1;
    localparam sel_t LH_LRD  = 2'd2;

    // Walk pointer update (prev and cur)
    localparam sel_t PT_HOLD = 2'd0;
    localparam sel_t PT_LIST = 2'd1;
    localparam sel_t PT_LRD  = 2'd2;
    localparam sel_t PT_CUR  = 2'd3;

    // Hop counter update
    localparam sel_t CN_HOLD = 2'd0;
    localparam sel_t CN_ZERO = 2'd1;
    localparam sel_t CN_ONE  = 2'd2;
    localparam sel_t CN_INC  = 2'd3;

    // Result slot select
    localparam sel_t SL_ZERO = 2'd0;
    localparam sel_t SL_N    = 2'd1;
    localparam sel_t SL_CUR  = 2'd2;

    typedef struct packed {
        logic                latch;
        logic                rd_en;
        sel_t                rd_sel;
        logic                vwr_en;
        logic                lwr_en;
        sel_t                lwr_addr;
        sel_t                lwr_data;
        sel_t                fh_op;
        sel_t                lh_op;
        logic                n_load;
        sel_t                prev_op;
        sel_t                cur_op;
        sel_t                cnt_op;
        logic                emit;
        logic [STATUS_W-1:0] emit_status;
        sel_t                emit_slot;
        logic                emit_dump;
    } ilp_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             pos_zero;
        logic             pos_one;
        logic             fh_nil;
        logic             lh_nil;
        logic             lrd_nil;
        logic             ins_more;
        logic             del_at;
        logic             dump_last;
    } ilp_stat_t;

endpackage

`default_nettype wire

// ----- sv/indexed_linked_list_pool_core.sv -----
// Channel   Handshake              Payload
// in        in_valid / in_ready    command, position, value
// out       out_valid / out_ready  status, item_value, slot, last
//
// One command at a time. Insert at the head pops a free slot and links it in;
// elsewhere it walks position - 1 hops, then links new slot and predecessor;
// delete walks position hops, then unlinks and frees; dump emits each element.
// The link store, read one hop per cycle unless a dump stalls, sets the pace.
// Reset empties the list and chains every slot on the free list at once.
// A stalled output holds a dump walk and each final result; the next command
// is taken while the last result still waits in the output register.
`default_nettype none

module indexed_linked_list_pool_core #(
    parameter int CAPACITY = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic        [ilp_pkg::CMD_W-1:0]     command,
    input  logic        [ilp_pkg::POS_W-1:0]     position,
    input  logic signed [ilp_pkg::VALUE_W-1:0]   value,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic        [ilp_pkg::STATUS_W-1:0]  status,
    output logic signed [ilp_pkg::VALUE_W-1:0]   item_value,
    output logic        [ilp_pkg::SLOT_W-1:0]    slot,
    output logic                                 last
);
    import ilp_pkg::*;

    ilp_cmd_t  cmd;
    ilp_stat_t stat;

    logic                       out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]        status_reg;
    logic signed [VALUE_W-1:0]  item_value_reg;
    logic [SLOT_W-1:0]          slot_reg;
    logic                       last_reg;
    logic                       out_free;

    logic [STATUS_W-1:0]        emit_status;
    logic signed [VALUE_W-1:0]  emit_value;
    logic [SLOT_W-1:0]          emit_slot;
    logic                       emit_last;

    // Sequencer: walks the list and issues store and pointer updates
    ilp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .out_free (out_free),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Link and value stores, head pointers and walk registers
    ilp_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .command     (command),
        .position    (position),
        .value       (value),
        .stat        (stat),
        .emit_status (emit_status),
        .emit_value  (emit_value),
        .emit_slot   (emit_slot),
        .emit_last   (emit_last)
    );

    // Output register: the sequencer emits only when this stage is free
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Load the result payload with each emitted item
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            status_reg     <= emit_status;
            item_value_reg <= emit_value;
            slot_reg       <= emit_slot;
            last_reg       <= emit_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign item_value = item_value_reg;
    assign slot       = slot_reg;
    assign last       = last_reg;

endmodule

`default_nettype wire

// ----- sv/ilp_datapath.sv -----
`default_nettype none

module ilp_datapath #(
    parameter int CAPACITY = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  ilp_pkg::ilp_cmd_t                    cmd,
    input  logic        [ilp_pkg::CMD_W-1:0]     command,
    input  logic        [ilp_pkg::POS_W-1:0]     position,
    input  logic signed [ilp_pkg::VALUE_W-1:0]   value,
    output ilp_pkg::ilp_stat_t                   stat,
    output logic        [ilp_pkg::STATUS_W-1:0]  emit_status,
    output logic signed [ilp_pkg::VALUE_W-1:0]   emit_value,
    output logic        [ilp_pkg::SLOT_W-1:0]    emit_slot,
    output logic                                 emit_last
);
    import ilp_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int LW = $clog2(CAPACITY + 1);
    localparam int CW = POS_W + 1;
    localparam logic [LW-1:0] NIL = LW'(CAPACITY);

    logic [CMD_W-1:0]   cmd_code_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [VALUE_W-1:0] val_reg;
    logic [LW-1:0]      list_head_reg, list_head_next;
    logic [LW-1:0]      free_head_reg, free_head_next;
    logic [LW-1:0]      n_reg;
    logic [LW-1:0]      prev_reg, prev_next;
    logic [LW-1:0]      cur_reg, cur_next;
    logic [POS_W-1:0]   cnt_reg, cnt_next;
    logic [LW-1:0]      lrd_reg;
    logic [VALUE_W-1:0] vrd_reg;
    logic [CAPACITY-1:0] lvalid_reg;

    logic [LW-1:0]      link_mem  [CAPACITY];
    logic [VALUE_W-1:0] value_mem [CAPACITY];

    logic [AW-1:0]  rd_addr;
    logic [AW-1:0]  wr_addr;
    logic [LW-1:0]  wr_data;
    logic [LW-1:0]  lrd_norm;
    logic [CW-1:0]  cnt_p1;
    logic           lrd_nil;
    logic           dump_last;

    assign lrd_nil  = lrd_reg >= NIL;
    assign lrd_norm = lrd_nil ? NIL : lrd_reg;
    assign cnt_p1   = CW'(cnt_reg) + CW'(1);
    assign dump_last = lrd_nil || (cnt_reg == POS_W'(CAPACITY - 1));

    always_comb
    begin
        case (cmd.rd_sel)
            RA_LIST: rd_addr = list_head_reg[AW-1:0];
            RA_LRD:  rd_addr = lrd_reg[AW-1:0];
            default: rd_addr = free_head_reg[AW-1:0];
        endcase
        case (cmd.lwr_addr)
            WA_PREV: wr_addr = prev_reg[AW-1:0];
            WA_CUR:  wr_addr = cur_reg[AW-1:0];
            default: wr_addr = n_reg[AW-1:0];
        endcase
        case (cmd.lwr_data)
            WD_LRD:  wr_data = lrd_reg;
            WD_N:    wr_data = n_reg;
            WD_FREE: wr_data = free_head_reg;
            default: wr_data = list_head_reg;
        endcase
    end

    // Link and value stores; an unwritten link reads as its reset chain
    always_ff @(posedge clk)
    begin
        if (cmd.lwr_en)
        begin
            link_mem[wr_addr] <= wr_data;
        end
        if (cmd.vwr_en)
        begin
            value_mem[free_head_reg[AW-1:0]] <= val_reg;
        end
        if (cmd.rd_en)
        begin
            lrd_reg <= lvalid_reg[rd_addr] ? link_mem[rd_addr] : LW'(rd_addr) + LW'(1);
            vrd_reg <= value_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lvalid_reg    <= '0;
            list_head_reg <= NIL;
            free_head_reg <= '0;
        end
        else
        begin
            if (cmd.lwr_en)
            begin
                lvalid_reg[wr_addr] <= 1'b1;
            end
            list_head_reg <= list_head_next;
            free_head_reg <= free_head_next;
        end
    end

    always_comb
    begin
        case (cmd.fh_op)
            FH_POP:      free_head_next = lrd_norm;
            FH_PUSH_N:   free_head_next = n_reg;
            FH_PUSH_CUR: free_head_next = cur_reg;
            default:     free_head_next = free_head_reg;
        endcase
        case (cmd.lh_op)
            LH_N:    list_head_next = n_reg;
            LH_LRD:  list_head_next = lrd_norm;
            default: list_head_next = list_head_reg;
        endcase
        case (cmd.prev_op)
            PT_LIST: prev_next = list_head_reg;
            PT_LRD:  prev_next = lrd_reg;
            PT_CUR:  prev_next = cur_reg;
            default: prev_next = prev_reg;
        endcase
        case (cmd.cur_op)
            PT_LIST: cur_next = list_head_reg;
            PT_LRD:  cur_next = lrd_reg;
            PT_CUR:  cur_next = cur_reg;
            default: cur_next = cur_reg;
        endcase
        case (cmd.cnt_op)
            CN_ZERO: cnt_next = '0;
            CN_ONE:  cnt_next = POS_W'(1);
            CN_INC:  cnt_next = cnt_reg + POS_W'(1);
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            cmd_code_reg <= command;
            pos_reg      <= position;
            val_reg      <= value;
        end
        if (cmd.n_load)
        begin
            n_reg <= free_head_reg;
        end
        prev_reg <= prev_next;
        cur_reg  <= cur_next;
        cnt_reg  <= cnt_next;
    end

    always_comb
    begin
        stat.cmd       = cmd_code_reg;
        stat.pos_zero  = pos_reg == '0;
        stat.pos_one   = pos_reg == POS_W'(1);
        stat.fh_nil    = free_head_reg >= NIL;
        stat.lh_nil    = list_head_reg >= NIL;
        stat.lrd_nil   = lrd_nil;
        stat.ins_more  = cnt_p1 < CW'(pos_reg);
        stat.del_at    = cnt_p1 == CW'(pos_reg);
        stat.dump_last = dump_last;
    end

    always_comb
    begin
        emit_status = cmd.emit_status;
        emit_value  = cmd.emit_dump ? vrd_reg : '0;
        emit_last   = cmd.emit_dump ? dump_last : 1'b1;
        case (cmd.emit_slot)
            SL_N:    emit_slot = SLOT_W'(n_reg);
            SL_CUR:  emit_slot = SLOT_W'(cur_reg);
            default: emit_slot = '0;
        endcase
    end

endmodule

`default_nettype wire

// ----- sv/ilp_ctrl.sv -----
`default_nettype none

module ilp_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               out_free,
    input  ilp_pkg::ilp_stat_t stat,
    output ilp_pkg::ilp_cmd_t  cmd
);
    import ilp_pkg::*;

    localparam logic [3:0] S_IDLE       = 4'd0;
    localparam logic [3:0] S_DECODE     = 4'd1;
    localparam logic [3:0] S_INS_POP    = 4'd2;
    localparam logic [3:0] S_INS_STEP   = 4'd3;
    localparam logic [3:0] S_INS_LINK   = 4'd4;
    localparam logic [3:0] S_INS_LINK2  = 4'd5;
    localparam logic [3:0] S_INS_REL    = 4'd6;
    localparam logic [3:0] S_DEL_HEAD   = 4'd7;
    localparam logic [3:0] S_DEL_STEP   = 4'd8;
    localparam logic [3:0] S_DEL_UNLINK = 4'd9;
    localparam logic [3:0] S_DEL_FREE   = 4'd10;
    localparam logic [3:0] S_DUMP       = 4'd11;

    logic [3:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = state_reg == S_IDLE;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (stat.cmd)
                    CMD_INSERT:
                    begin
                        if (stat.fh_nil)
                        begin
                            if (out_free)
                            begin
                                cmd.emit        = 1'b1;
                                cmd.emit_status = ST_FULL;
                                state_next      = S_IDLE;
                            end
                        end
                        else
                        begin
                            cmd.vwr_en = 1'b1;
                            cmd.n_load = 1'b1;
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RA_FREE;
                            state_next = S_INS_POP;
                        end
                    end
                    CMD_DELETE, CMD_DUMP:
                    begin
                        if (stat.lh_nil)
                        begin
                            if (out_free)
                            begin
                                cmd.emit        = 1'b1;
                                cmd.emit_status = ST_EMPTY;
                                state_next      = S_IDLE;
                            end
                        end
                        else
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RA_LIST;
                            cmd.cur_op = PT_LIST;
                            cmd.cnt_op = CN_ZERO;
                            if (stat.cmd == CMD_DUMP)
                            begin
                                state_next = S_DUMP;
                            end
                            else if (stat.pos_zero)
                            begin
                                state_next = S_DEL_HEAD;
                            end
                            else
                            begin
                                state_next = S_DEL_STEP;
                            end
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_INS_POP:
            begin
                if (stat.pos_zero)
                begin
                    if (out_free)
                    begin
                        cmd.fh_op       = FH_POP;
                        cmd.lwr_en      = 1'b1;
                        cmd.lwr_addr    = WA_N;
                        cmd.lwr_data    = WD_LIST;
                        cmd.lh_op       = LH_N;
                        cmd.emit        = 1'b1;
                        cmd.emit_status = ST_OK;
                        cmd.emit_slot   = SL_N;
                        state_next      = S_IDLE;
                    end
                end
                else
                begin
                    cmd.fh_op = FH_POP;
                    if (stat.lh_nil)
                    begin
                        state_next = S_INS_REL;
                    end
                    else
                    begin
                        cmd.rd_en   = 1'b1;
                        cmd.rd_sel  = RA_LIST;
                        cmd.prev_op = PT_LIST;
                        cmd.cnt_op  = CN_ONE;
                        state_next  = stat.pos_one ? S_INS_LINK : S_INS_STEP;
                    end
                end
            end
            S_INS_STEP:
            begin
                if (stat.lrd_nil)
                begin
                    state_next = S_INS_REL;
                end
                else
                begin
                    cmd.prev_op = PT_LRD;
                    cmd.cnt_op  = CN_INC;
                    cmd.rd_en   = 1'b1;
                    cmd.rd_sel  = RA_LRD;
                    if (!stat.ins_more)
                    begin
                        state_next = S_INS_LINK;
                    end
                end
            end
            S_INS_LINK:
            begin
                cmd.lwr_en   = 1'b1;
                cmd.lwr_addr = WA_N;
                cmd.lwr_data = WD_LRD;
                state_next   = S_INS_LINK2;
            end
            S_INS_LINK2:
            begin
                if (out_free)
                begin
                    cmd.lwr_en      = 1'b1;
                    cmd.lwr_addr    = WA_PREV;
                    cmd.lwr_data    = WD_N;
                    cmd.emit        = 1'b1;
                    cmd.emit_status = ST_OK;
                    cmd.emit_slot   = SL_N;
                    state_next      = S_IDLE;
                end
            end
            S_INS_REL:
            begin
                if (out_free)
                begin
                    cmd.lwr_en      = 1'b1;
                    cmd.lwr_addr    = WA_N;
                    cmd.lwr_data    = WD_FREE;
                    cmd.fh_op       = FH_PUSH_N;
                    cmd.emit        = 1'b1;
                    cmd.emit_status = ST_OOB;
                    state_next      = S_IDLE;
                end
            end
            S_DEL_HEAD:
            begin
                if (out_free)
                begin
                    cmd.lh_op       = LH_LRD;
                    cmd.lwr_en      = 1'b1;
                    cmd.lwr_addr    = WA_CUR;
                    cmd.lwr_data    = WD_FREE;
                    cmd.fh_op       = FH_PUSH_CUR;
                    cmd.emit        = 1'b1;
                    cmd.emit_status = ST_OK;
                    cmd.emit_slot   = SL_CUR;
                    state_next      = S_IDLE;
                end
            end
            S_DEL_STEP:
            begin
                if (stat.lrd_nil)
                begin
                    if (out_free)
                    begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = ST_OOB;
                        state_next      = S_IDLE;
                    end
                end
                else
                begin
                    cmd.prev_op = PT_CUR;
                    cmd.cur_op  = PT_LRD;
                    cmd.cnt_op  = CN_INC;
                    cmd.rd_en   = 1'b1;
                    cmd.rd_sel  = RA_LRD;
                    if (stat.del_at)
                    begin
                        state_next = S_DEL_UNLINK;
                    end
                end
            end
            S_DEL_UNLINK:
            begin
                cmd.lwr_en   = 1'b1;
                cmd.lwr_addr = WA_PREV;
                cmd.lwr_data = WD_LRD;
                state_next   = S_DEL_FREE;
            end
            S_DEL_FREE:
            begin
                if (out_free)
                begin
                    cmd.lwr_en      = 1'b1;
                    cmd.lwr_addr    = WA_CUR;
                    cmd.lwr_data    = WD_FREE;
                    cmd.fh_op       = FH_PUSH_CUR;
                    cmd.emit        = 1'b1;
                    cmd.emit_status = ST_OK;
                    cmd.emit_slot   = SL_CUR;
                    state_next      = S_IDLE;
                end
            end
            S_DUMP:
            begin
                if (out_free)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = ST_OK;
                    cmd.emit_slot   = SL_CUR;
                    cmd.emit_dump   = 1'b1;
                    if (stat.dump_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.cur_op = PT_LRD;
                        cmd.cnt_op = CN_INC;
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RA_LRD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire
